// ===== design/sdts_pkg.sv =====
`default_nettype none
package sdts_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FUNC_BEGIN   = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_ABORT   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ACT_INLINE     = 3'd0,
    ACT_READ_BLOCK = 3'd1,
    ACT_RECEIVE    = 3'd2,
    ACT_DELAY      = 3'd3,
    ACT_WRITE_BLOCK = 3'd4,
    ACT_STATUS     = 3'd5,
    ACT_END        = 3'd6
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_SENSE       = 4'd1,
    PH_TUR         = 4'd2,
    PH_READ_CHECK  = 4'd3,
    PH_READ_XFER   = 4'd4,
    PH_WRITE_CHECK = 4'd5,
    PH_WRITE_WAIT  = 4'd6,
    PH_WRITE_XFER  = 4'd7,
    PH_INQUIRY     = 4'd8,
    PH_CAPACITY    = 4'd9,
    PH_UNKNOWN     = 4'd10,
    PH_STATUS      = 4'd11,
    PH_COMPLETE    = 4'd12
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROTECTED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOLID_STATE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_256  = 2'd3;

  localparam logic [7:0] OP_TEST_READY = 8'h00;
  localparam logic [7:0] OP_REQ_SENSE  = 8'h03;
  localparam logic [7:0] OP_READ6      = 8'h08;
  localparam logic [7:0] OP_READ10     = 8'h28;
  localparam logic [7:0] OP_WRITE6     = 8'h0A;
  localparam logic [7:0] OP_WRITE10    = 8'h2A;
  localparam logic [7:0] OP_INQUIRY    = 8'h12;
  localparam logic [7:0] OP_CAPACITY   = 8'h25;

  localparam logic [7:0] GROUP_MASK = 8'hE0;
  localparam logic [7:0] GROUP_0    = 8'h00;
  localparam logic [7:0] GROUP_1    = 8'h20;

  localparam logic [7:0] SENSE_NONE      = 8'h00;
  localparam logic [7:0] SENSE_ADDRESS   = 8'h21;
  localparam logic [7:0] SENSE_PROTECTED = 8'h17;
  localparam logic [7:0] SENSE_WRITE_ERR = 8'h11;
  localparam logic [7:0] SENSE_BAD_FIELD = 8'h70;

  localparam logic [7:0]  STATUS_GOOD      = 8'h80;
  localparam logic [7:0]  STATUS_CHECK     = 8'h82;
  localparam logic [63:0] SEEK_DELAY_US    = 64'd5500;
  localparam logic [9:0]  BYTES_FULL       = 10'd512;
  localparam logic [9:0]  BYTES_HALF       = 10'd256;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] opcode;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b7;
    logic [7:0] b8;
    logic       store_fault;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [9:0]  transfer_length;
    logic [63:0] reply_bytes;
    logic [31:0] disk_sector;
    logic        sector_half;
  } result_t;

  typedef struct packed {
    logic [31:0] sector_count;
    logic        write_protected;
    logic        solid_state;
    logic        block_size_256;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/sdts_core.sv =====
`default_nettype none
module sdts_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  sdts_pkg::item_t       item,
  input  sdts_pkg::cfg_t        cfg,
  output logic                  res_valid,
  output sdts_pkg::result_t     res
);
  import sdts_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] next_block_r, next_block_nxt;
  logic [16:0] blocks_left_r, blocks_left_nxt;
  logic [7:0]  sense_r, sense_nxt;
  logic        clr_pend_r, clr_pend_nxt;
  logic        evpd_r, evpd_nxt;

  logic [32:0] bound;
  logic [31:0] bound_m1;
  logic        out_of_range;
  logic [9:0]  blk_bytes;
  logic [31:0] blk_sector;
  logic        blk_half;
  logic [16:0] left_dec;
  logic [31:0] block_inc;

  // The bound is counted in logical blocks, so it doubles in 256-byte mode.
  assign bound        = cfg.block_size_256 ? {cfg.sector_count, 1'b0}
                                           : {1'b0, cfg.sector_count};
  assign bound_m1     = bound[31:0] - 32'd1;
  assign out_of_range = {1'b0, next_block_r} >= bound;
  assign blk_bytes    = cfg.block_size_256 ? BYTES_HALF : BYTES_FULL;
  assign blk_sector   = cfg.block_size_256 ? {1'b0, next_block_r[31:1]} : next_block_r;
  assign blk_half     = cfg.block_size_256 & next_block_r[0];
  assign left_dec     = blocks_left_r - 17'd1;
  assign block_inc    = next_block_r + 32'd1;

  always_comb begin
    phase_nxt       = phase_r;
    next_block_nxt  = next_block_r;
    blocks_left_nxt = blocks_left_r;
    sense_nxt       = sense_r;
    clr_pend_nxt    = clr_pend_r;
    evpd_nxt        = evpd_r;
    res_valid       = 1'b0;
    res             = '0;

    if (fire) begin
      unique case (item.func)
        FUNC_BEGIN: begin
          if (clr_pend_r && item.opcode != OP_INQUIRY) begin
            clr_pend_nxt = 1'b0;
            sense_nxt    = SENSE_NONE;
          end
          evpd_nxt = item.b1[0];
          if ((item.opcode & GROUP_MASK) == GROUP_0) begin
            next_block_nxt  = {11'd0, item.b1[4:0], item.b2, item.b3};
            blocks_left_nxt = (item.b4 != 8'd0) ? {9'd0, item.b4} : 17'd256;
          end else if ((item.opcode & GROUP_MASK) == GROUP_1) begin
            next_block_nxt  = {item.b2, item.b3, item.b4, item.b5};
            blocks_left_nxt = ({item.b7, item.b8} != 16'd0) ? {1'b0, item.b7, item.b8}
                                                            : 17'h10000;
          end
          unique case (item.opcode)
            OP_TEST_READY:        phase_nxt = PH_TUR;
            OP_REQ_SENSE:         phase_nxt = PH_SENSE;
            OP_READ6, OP_READ10:  phase_nxt = PH_READ_CHECK;
            OP_WRITE6, OP_WRITE10: phase_nxt = PH_WRITE_CHECK;
            OP_INQUIRY:           phase_nxt = PH_INQUIRY;
            OP_CAPACITY:          phase_nxt = PH_CAPACITY;
            default:              phase_nxt = PH_UNKNOWN;
          endcase
        end

        FUNC_ADVANCE: begin
          unique case (phase_r)
            PH_SENSE: begin
              clr_pend_nxt        = 1'b1;
              res_valid           = 1'b1;
              res.action          = ACT_INLINE;
              res.transfer_length = 10'd4;
              res.reply_bytes     = {sense_r, 56'd0};
              phase_nxt           = PH_STATUS;
            end
            PH_TUR: begin
              sense_nxt = SENSE_NONE;
              phase_nxt = PH_STATUS;
            end
            PH_READ_CHECK: begin
              if (out_of_range) begin
                sense_nxt = SENSE_ADDRESS;
                phase_nxt = PH_STATUS;
              end else begin
                phase_nxt = PH_READ_XFER;
                if (!cfg.solid_state) begin
                  res_valid       = 1'b1;
                  res.action      = ACT_DELAY;
                  res.reply_bytes = SEEK_DELAY_US;
                end
              end
            end
            PH_READ_XFER, PH_WRITE_XFER: begin
              if (item.store_fault) begin
                sense_nxt = (phase_r == PH_READ_XFER) ? SENSE_ADDRESS : SENSE_WRITE_ERR;
                phase_nxt = PH_STATUS;
              end else begin
                res_valid           = 1'b1;
                res.action          = (phase_r == PH_READ_XFER) ? ACT_READ_BLOCK
                                                                : ACT_WRITE_BLOCK;
                res.transfer_length = blk_bytes;
                res.disk_sector     = blk_sector;
                res.sector_half     = blk_half;
                next_block_nxt      = block_inc;
                blocks_left_nxt     = left_dec;
                if (left_dec != 17'd0) begin
                  phase_nxt = (phase_r == PH_READ_XFER) ? PH_READ_XFER : PH_WRITE_CHECK;
                end else begin
                  sense_nxt = SENSE_NONE;
                  phase_nxt = PH_STATUS;
                end
              end
            end
            PH_WRITE_CHECK: begin
              if (cfg.write_protected) begin
                sense_nxt = SENSE_PROTECTED;
                phase_nxt = PH_STATUS;
              end else if (out_of_range) begin
                sense_nxt = SENSE_ADDRESS;
                phase_nxt = PH_STATUS;
              end else begin
                res_valid           = 1'b1;
                res.action          = ACT_RECEIVE;
                res.transfer_length = blk_bytes;
                phase_nxt           = PH_WRITE_WAIT;
              end
            end
            PH_WRITE_WAIT: begin
              phase_nxt = PH_WRITE_XFER;
              if (!cfg.solid_state) begin
                res_valid       = 1'b1;
                res.action      = ACT_DELAY;
                res.reply_bytes = SEEK_DELAY_US;
              end
            end
            PH_INQUIRY: begin
              phase_nxt = PH_STATUS;
              if (evpd_r) begin
                sense_nxt = SENSE_BAD_FIELD;
              end else begin
                res_valid           = 1'b1;
                res.action          = ACT_INLINE;
                res.transfer_length = 10'd2;
                sense_nxt           = SENSE_NONE;
              end
            end
            PH_CAPACITY: begin
              res_valid           = 1'b1;
              res.action          = ACT_INLINE;
              res.transfer_length = 10'd8;
              res.reply_bytes     = {bound_m1, 22'd0, blk_bytes};
              sense_nxt           = SENSE_NONE;
              phase_nxt           = PH_STATUS;
            end
            PH_UNKNOWN: begin
              phase_nxt = PH_STATUS;
            end
            PH_STATUS: begin
              res_valid           = 1'b1;
              res.action          = ACT_STATUS;
              res.transfer_length = 10'd2;
              res.reply_bytes     = {(sense_r != SENSE_NONE) ? STATUS_CHECK : STATUS_GOOD,
                                     56'd0};
              phase_nxt           = PH_COMPLETE;
            end
            PH_COMPLETE: begin
              res_valid  = 1'b1;
              res.action = ACT_END;
              phase_nxt  = PH_IDLE;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end

        FUNC_ABORT: begin
          phase_nxt = PH_IDLE;
        end

        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      next_block_r  <= '0;
      blocks_left_r <= '0;
      sense_r       <= SENSE_NONE;
      clr_pend_r    <= 1'b0;
      evpd_r        <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      next_block_r  <= next_block_nxt;
      blocks_left_r <= blocks_left_nxt;
      sense_r       <= sense_nxt;
      clr_pend_r    <= clr_pend_nxt;
      evpd_r        <= evpd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/scsi_disk_target_sequencer.sv =====
`default_nettype none
// Disk target command sequencer. A begin beat loads a command block, each advance
// beat yields at most one bus or store action, and an abort beat returns to idle.
// One item is taken per clock cycle while the input is not stalled; an accepted
// item is held in an input register, decoded against the phase state in one pass,
// and its result is loaded into the output register once that register is free
// or being drained. The output register decouples the sides, so input stalls
// only while a result is waiting and out_ready is low. Configuration writes are
// always accepted and should be made only while the sequencer is idle.
module scsi_disk_target_sequencer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_func,
  input  wire logic [7:0]                     in_opcode,
  input  wire logic [7:0]                     in_cdb_byte1,
  input  wire logic [7:0]                     in_cdb_byte2,
  input  wire logic [7:0]                     in_cdb_byte3,
  input  wire logic [7:0]                     in_cdb_byte4,
  input  wire logic [7:0]                     in_cdb_byte5,
  input  wire logic [7:0]                     in_cdb_byte7,
  input  wire logic [7:0]                     in_cdb_byte8,
  input  wire logic                           in_store_fault,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          out_action,
  output logic [9:0]                          out_transfer_length,
  output logic [63:0]                         out_reply_bytes,
  output logic [31:0]                         out_disk_sector,
  output logic                                out_sector_half,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sdts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import sdts_pkg::*;

  item_t   item_r;
  logic    item_valid_r, item_valid_nxt;
  cfg_t    cfg_r;
  result_t out_r;
  logic    out_valid_r, out_valid_nxt;
  logic    move;
  logic    fire;
  logic    res_valid;
  result_t res;

  // The pipeline moves whenever the output register is free or being drained.
  assign move      = !out_valid_r || out_ready;
  assign fire      = item_valid_r && move;
  assign in_ready  = !item_valid_r || move;
  assign cfg_ready = 1'b1;

  assign item_valid_nxt = in_ready ? in_valid : item_valid_r;
  assign out_valid_nxt  = move ? (fire && res_valid) : out_valid_r;

  sdts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cfg_r        <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SECTOR_COUNT:    cfg_r.sector_count    <= cfg_data;
          CFG_WRITE_PROTECTED: cfg_r.write_protected <= cfg_data[0];
          CFG_SOLID_STATE:     cfg_r.solid_state     <= cfg_data[0];
          CFG_BLOCK_SIZE_256:  cfg_r.block_size_256  <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{func: in_func, opcode: in_opcode, b1: in_cdb_byte1, b2: in_cdb_byte2,
                  b3: in_cdb_byte3, b4: in_cdb_byte4, b5: in_cdb_byte5, b7: in_cdb_byte7,
                  b8: in_cdb_byte8, store_fault: in_store_fault};
    end
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_action          = out_r.action;
  assign out_transfer_length = out_r.transfer_length;
  assign out_reply_bytes     = out_r.reply_bytes;
  assign out_disk_sector     = out_r.disk_sector;
  assign out_sector_half     = out_r.sector_half;

endmodule
`default_nettype wire
